### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared helpers for concurrent checks with clock, async active-low reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define CHK_PROP(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in this cycle implies consequent in the next
`define CHK_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/mwps_pkg.sv
// ----------------------------------------------------------------------------
// mwps_pkg
// types, sizes and helpers for the multichannel wavetable phase stepper
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mwps_pkg;

  localparam int CHANNELS = 4;
  localparam int STEPS    = 8;
  localparam int PHASES   = 4;

  localparam int GROUP     = PHASES + 1;
  localparam int PIN_W     = 20;
  localparam int PIN_IDX_W = $clog2(PIN_W);
  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int STEP_W    = $clog2(STEPS);
  localparam int TOTAL_W   = $clog2(CHANNELS + 1);
  localparam int WAVE_W    = 32;
  localparam int PERIOD_W  = 16;

  localparam logic [1:0] FUNC_TICK     = 2'd0;
  localparam logic [1:0] FUNC_NOTE_ON  = 2'd1;
  localparam logic [1:0] FUNC_NOTE_OFF = 2'd2;
  localparam logic [1:0] FUNC_STOP_ALL = 2'd3;

  typedef struct packed {
    logic [1:0]          func;
    logic [1:0]          channel_index;
    logic [PERIOD_W-1:0] note_period;
  } in_t;

  typedef struct packed {
    logic [PIN_W-1:0] pin_levels;
    logic [2:0]       active_count;
  } out_t;

  // phase pattern of one wavetable row, bits past the register read low
  function automatic logic [PHASES-1:0] wave_row(logic [WAVE_W-1:0] wave,
                                                 logic [STEP_W-1:0] s);
    logic [PHASES-1:0] row;
    int pos;
    row = '0;
    for (int p = 0; p < PHASES; p++) begin
      pos = int'(s) * PHASES + p;
      if (pos < WAVE_W) begin
        row[p] = wave[5'(pos)];
      end
    end
    return row;
  endfunction

  // active count as reported, saturating at seven
  function automatic logic [2:0] sat_count(logic [TOTAL_W-1:0] total);
    logic [2:0] res;
    if (int'(total) > 7) begin
      res = 3'd7;
    end else begin
      res = 3'(total);
    end
    return res;
  endfunction

endpackage

### sv/multichannel_wavetable_phase_stepper.sv
// ----------------------------------------------------------------------------
// multichannel_wavetable_phase_stepper
// per-channel period counters step a wavetable onto each channel's phase pins
// ----------------------------------------------------------------------------
// note on, note off, stop all and idle ticks give a result in the next cycle;
// a tick with an active channel first walks all channels: one shared compare
// and increment unit visits one channel per cycle, each with its own counter
// the input stalls while a tick walks the channels or a result waits to be taken
// reset clears all periods, counters, steps, pins, count and the wavetable
`timescale 1ns / 1ps

module multichannel_wavetable_phase_stepper import mwps_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_t                 in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_t                out_data_o,
  input  logic                cfg_we_i,
  input  logic [WAVE_W-1:0]   cfg_wdata_i
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_TICK = 1'b1;

  logic                state_q, state_d;
  logic [CH_W-1:0]     ch_q, ch_d;
  logic                out_valid_q, out_valid_d;
  logic [WAVE_W-1:0]   wave_q;
  logic [PERIOD_W-1:0] period_q [CHANNELS];
  logic [PERIOD_W-1:0] period_d [CHANNELS];
  logic [PERIOD_W-1:0] cnt_q    [CHANNELS];
  logic [PERIOD_W-1:0] cnt_d    [CHANNELS];
  logic [STEP_W-1:0]   step_q   [CHANNELS];
  logic [STEP_W-1:0]   step_d   [CHANNELS];
  logic [CHANNELS-1:0] active_q, active_d;
  logic [TOTAL_W-1:0]  total_q, total_d;
  logic [PIN_W-1:0]    pins_q, pins_d;

  logic            accept;
  logic            ch_ok;
  logic [CH_W-1:0] ch_sel;

  assign in_stall_o  = (state_q != ST_IDLE) | out_valid_q;
  assign accept      = in_valid_i & ~in_stall_o;
  assign ch_ok       = int'(in_data_i.channel_index) < CHANNELS;
  assign ch_sel      = CH_W'(in_data_i.channel_index);
  assign out_valid_o = out_valid_q;

  assign out_data_o.pin_levels   = pins_q;
  assign out_data_o.active_count = sat_count(total_q);

  always_comb begin
    int                pos;
    logic [STEP_W:0]   nxt;
    logic [PHASES-1:0] row;
    state_d     = state_q;
    ch_d        = ch_q;
    out_valid_d = out_valid_q;
    period_d    = period_q;
    cnt_d       = cnt_q;
    step_d      = step_q;
    active_d    = active_q;
    total_d     = total_q;
    pins_d      = pins_q;
    nxt         = '0;
    row         = '0;
    pos         = 0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          out_valid_d = 1'b1;
          unique case (in_data_i.func)
            FUNC_TICK: begin
              if (total_q != '0) begin
                out_valid_d = 1'b0;
                state_d     = ST_TICK;
                ch_d        = '0;
              end
            end
            FUNC_NOTE_ON: begin
              if (ch_ok) begin
                active_d[ch_sel] = 1'b1;
                period_d[ch_sel] = in_data_i.note_period;
                if (!active_q[ch_sel]) begin
                  total_d = total_q + TOTAL_W'(1);
                end
                pos = int'(ch_sel) * GROUP;
                if (pos < PIN_W) begin
                  pins_d[PIN_IDX_W'(pos)] = 1'b1;
                end
              end
            end
            FUNC_NOTE_OFF: begin
              if (ch_ok) begin
                active_d[ch_sel] = 1'b0;
                period_d[ch_sel] = '0;
                cnt_d[ch_sel]    = '0;
                if (active_q[ch_sel] && total_q != '0) begin
                  total_d = total_q - TOTAL_W'(1);
                end
                for (int p = 0; p < GROUP; p++) begin
                  pos = int'(ch_sel) * GROUP + p;
                  if (pos < PIN_W) begin
                    pins_d[PIN_IDX_W'(pos)] = 1'b0;
                  end
                end
              end
            end
            FUNC_STOP_ALL: begin
              for (int c = 0; c < CHANNELS; c++) begin
                active_d[c] = 1'b0;
                period_d[c] = '0;
                cnt_d[c]    = '0;
              end
              total_d = '0;
              pins_d  = '0;
            end
          endcase
        end
      end
      ST_TICK: begin
        // shared compare and increment on the channel under visit
        if (period_q[ch_q] != '0) begin
          if (cnt_q[ch_q] >= period_q[ch_q]) begin
            cnt_d[ch_q] = '0;
            nxt = {1'b0, step_q[ch_q]} + (STEP_W + 1)'(1);
            if (int'(nxt) >= STEPS) begin
              nxt = '0;
            end
            step_d[ch_q] = nxt[STEP_W-1:0];
            row = wave_row(wave_q, nxt[STEP_W-1:0]);
            for (int p = 0; p < PHASES; p++) begin
              pos = int'(ch_q) * GROUP + 1 + p;
              if (pos < PIN_W) begin
                pins_d[PIN_IDX_W'(pos)] = row[p];
              end
            end
          end else begin
            cnt_d[ch_q] = cnt_q[ch_q] + PERIOD_W'(1);
          end
        end
        if (ch_q == CH_W'(CHANNELS - 1)) begin
          state_d     = ST_IDLE;
          ch_d        = '0;
          out_valid_d = 1'b1;
        end else begin
          ch_d = ch_q + CH_W'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ch_q        <= '0;
      out_valid_q <= 1'b0;
      wave_q      <= '0;
      active_q    <= '0;
      total_q     <= '0;
      pins_q      <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        period_q[c] <= '0;
        cnt_q[c]    <= '0;
        step_q[c]   <= '0;
      end
    end else begin
      state_q     <= state_d;
      ch_q        <= ch_d;
      out_valid_q <= out_valid_d;
      active_q    <= active_d;
      total_q     <= total_d;
      pins_q      <= pins_d;
      period_q    <= period_d;
      cnt_q       <= cnt_d;
      step_q      <= step_d;
      if (cfg_we_i) begin
        wave_q <= cfg_wdata_i;
      end
    end
  end

endmodule

### sv/mwps_checker.sv
// ----------------------------------------------------------------------------
// mwps_checker
// port-level checks on the phase stepper, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mwps_checker import mwps_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input in_t               in_data_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input out_t              out_data_o,
  input logic              cfg_we_i,
  input logic [WAVE_W-1:0] cfg_wdata_i
);

  logic in_xfer;
  logic unused_cfg;
  logic stop_xfer;
  logic off0_xfer;
  logic all_clear;
  logic grp0_clear;
  logic count_ok;

  assign in_xfer    = in_valid_i & ~in_stall_o;
  assign unused_cfg = cfg_we_i ^ (^cfg_wdata_i);
  assign stop_xfer  = in_xfer && in_data_i.func == FUNC_STOP_ALL;
  assign off0_xfer  = in_xfer && in_data_i.func == FUNC_NOTE_OFF &&
                      in_data_i.channel_index == '0;
  assign all_clear  = out_valid_o && out_data_o.pin_levels == '0 &&
                      out_data_o.active_count == '0;
  assign grp0_clear = out_valid_o && out_data_o.pin_levels[GROUP-1:0] == '0;
  assign count_ok   = !out_valid_o || (int'(out_data_o.active_count) <= CHANNELS);

  // a result waiting to be taken stays offered
  `CHK_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o, "result dropped")

  // one item at a time: input stalls right after a transfer
  `CHK_NEXT(a_busy_after_xfer, clk_i, rst_ni, in_xfer, in_stall_o, "input taken while busy")

  // stop all leaves every pin and the count clear in the result that follows
  `CHK_NEXT(a_stop_all, clk_i, rst_ni, stop_xfer, all_clear, "stop all left state behind")

  // note off of channel 0 drives its whole pin group low
  `CHK_NEXT(a_note_off_ch0, clk_i, rst_ni, off0_xfer, grp0_clear, "note off left pins high")

  // count never exceeds the channel count
  `CHK_PROP(a_count_range, clk_i, rst_ni, count_ok, "active count out of range")

endmodule

bind multichannel_wavetable_phase_stepper mwps_checker u_mwps_checker (.*);
